[rtl/lsm_pkg.sv]
// Shared constants, codes and control structs for the bounded LIFO stack block.
// Used by lsm_ctrl, lsm_dp and lifo_stack_with_search_min_max; depends on nothing.
package lsm_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Field widths on the ports.
    localparam int ACT_W      = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int RESULT_W   = 32;
    localparam int OUT_CNT_W  = 11;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 48;

    typedef logic [ACT_W-1:0]    action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_PUSH   = 3'd0;
    localparam action_t ACT_POP    = 3'd1;
    localparam action_t ACT_SEARCH = 3'd2;
    localparam action_t ACT_MAX    = 3'd3;
    localparam action_t ACT_MIN    = 3'd4;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_FULL  = 2'd1;
    localparam status_t STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_DRAIN,
        CS_FINISH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // take the input beat and run push or pop at once
        logic rd_en;     // read the next stored entry for a scan
        logic load_out;  // move the result into the output register
    } lsm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_go;   // the incoming action needs a walk over the entries
        logic scan_last; // the current scan read is the topmost entry
    } lsm_stat_t;

endpackage

[rtl/lsm_ctrl.sv]
// Controller state machine of the LIFO stack: input handshake, scan sequencing
// and the output valid flag. Depends on lsm_pkg.
module lsm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output lsm_pkg::lsm_cmd_t cmd,
    input  lsm_pkg::lsm_stat_t stat
);
    import lsm_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= CS_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                // Nothing is taken while reset is held.
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.start  = 1'b1;
                    state_next = stat.scan_go ? CS_SCAN : CS_FINISH;
                end
            end
            CS_SCAN: begin
                cmd.rd_en = 1'b1;
                if (stat.scan_last) begin
                    state_next = CS_DRAIN;
                end
            end
            CS_DRAIN: begin
                // The last read word is compared in this cycle.
                state_next = CS_FINISH;
            end
            CS_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase

        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // A new result is only loaded when the previous one has left or is leaving.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while still held");

    // A scan always passes through the drain cycle before the result is loaded.
    a_drain_then_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_DRAIN) |=> (state_reg == CS_FINISH))
        else $error("drain cycle not followed by finish");

endmodule

[rtl/lsm_dp.sv]
// Datapath of the LIFO stack: entry memory, fill count, scan index, search and
// min/max comparison, and the output payload register. Depends on lsm_pkg.
module lsm_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lsm_pkg::lsm_cmd_t              cmd,
    output lsm_pkg::lsm_stat_t             stat,
    input  lsm_pkg::action_t               in_action,
    input  logic signed [lsm_pkg::VALUE_W-1:0] in_value,
    output lsm_pkg::status_t               out_status,
    output logic signed [lsm_pkg::RESULT_W-1:0] out_result_value,
    output logic                           out_found,
    output logic [lsm_pkg::OUT_CNT_W-1:0]  out_count,
    output logic                           out_empty_flag,
    output logic                           out_full_flag
);
    import lsm_pkg::*;

    logic [DATA_WIDTH-1:0]        mem [DEPTH];
    logic [CNT_W-1:0]             count_reg;
    logic [ADDR_W-1:0]            idx_reg;
    logic signed [DATA_WIDTH-1:0] rdata_reg;
    logic                         rd_vld_reg;
    logic                         first_reg;
    action_t                      action_reg;
    logic signed [DATA_WIDTH-1:0] value_reg;
    status_t                      status_reg;
    logic signed [DATA_WIDTH-1:0] best_reg;
    logic                         found_reg;

    logic                         stack_empty, is_full;
    logic                         push_ok, pop_ok, is_mm;
    logic signed [DATA_WIDTH-1:0] in_word;

    assign stack_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign in_word  = DATA_WIDTH'(in_value);
    assign push_ok  = cmd.start && (in_action == ACT_PUSH) && !is_full;
    assign pop_ok   = cmd.start && (in_action == ACT_POP) && !stack_empty;
    assign is_mm    = (action_reg == ACT_MAX) || (action_reg == ACT_MIN);

    assign stat.scan_go   = !stack_empty && ((in_action == ACT_SEARCH) ||
                            (in_action == ACT_MAX) || (in_action == ACT_MIN));
    assign stat.scan_last = (idx_reg == ADDR_W'(count_reg - CNT_W'(1)));

    // Entry memory: one write port for push, one registered read port for scans.
    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem[count_reg[ADDR_W-1:0]] <= in_word;
        end
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
            if (push_ok) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop_ok) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            action_reg <= in_action;
            value_reg  <= in_word;
            idx_reg    <= '0;
            first_reg  <= 1'b1;
            best_reg   <= '0;
            found_reg  <= 1'b0;
            if ((in_action == ACT_PUSH) && is_full) begin
                status_reg <= STAT_FULL;
            end else if (stack_empty && ((in_action == ACT_POP) ||
                         (in_action == ACT_MAX) || (in_action == ACT_MIN))) begin
                status_reg <= STAT_EMPTY;
            end else begin
                status_reg <= STAT_OK;
            end
        end else begin
            if (cmd.rd_en) begin
                idx_reg <= idx_reg + ADDR_W'(1);
            end
            if (rd_vld_reg) begin
                first_reg <= 1'b0;
                if ((action_reg == ACT_SEARCH) && (rdata_reg == value_reg)) begin
                    found_reg <= 1'b1;
                end
                if (is_mm && (first_reg ||
                    ((action_reg == ACT_MAX) && (rdata_reg > best_reg)) ||
                    ((action_reg == ACT_MIN) && (rdata_reg < best_reg)))) begin
                    best_reg <= rdata_reg;
                end
            end
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status       <= status_reg;
            out_result_value <= RESULT_W'(best_reg);
            out_found        <= found_reg;
            out_count        <= OUT_CNT_W'(count_reg);
            out_empty_flag   <= stack_empty;
            out_full_flag    <= is_full;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_full_push_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start && (in_action == ACT_PUSH) && is_full) |=> $stable(count_reg))
        else $error("refused push changed the fill count");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (CNT_W'(idx_reg) < count_reg))
        else $error("scan read beyond the stored entries");

    a_empty_no_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start && stack_empty) |-> !stat.scan_go)
        else $error("scan started on an empty stack");

endmodule

[rtl/lifo_stack_with_search_min_max.sv]
// Top level of the bounded LIFO stack with search, maximum and minimum.
// Instantiates lsm_ctrl and lsm_dp; depends on lsm_pkg.
//
//   Channel  Direction  tdata fields (low bit first)                      Beat
//   s_       in         action[2:0], value[34:3], zero pad to 40 bits    one action
//   m_       out        status[1:0], result_value[33:2], found[34],      one result
//                       count[45:35], empty_flag[46], full_flag[47]
//
// Push, pop, unknown actions and any action on an empty stack pass through the
// accept cycle, which also writes or moves the top, and a finish cycle that
// loads the output register. Search, maximum and minimum on a non-empty stack
// also read the entries, one entry per cycle, through the single read port of
// the entry memory, and pass a drain state. Reset clears the fill count and the
// control; the entry memory is not cleared, since only written entries are
// ever read. While a result waits on m_tready the next beat is still accepted
// and worked on; only its own finish cycle holds until the output register is free.
module lifo_stack_with_search_min_max (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // action[2:0], value[34:3], zeros[39:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status, result_value, found, count, empty, full
);
    import lsm_pkg::*;

    lsm_cmd_t                     cmd;
    lsm_stat_t                    stat;
    status_t                      out_status;
    logic signed [RESULT_W-1:0]   out_result_value;
    logic                         out_found;
    logic [OUT_CNT_W-1:0]         out_count;
    logic                         out_empty_flag;
    logic                         out_full_flag;

    // The controller owns the handshakes and the sequence of each action.
    lsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The datapath holds the entries, the fill count and the result register.
    lsm_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .in_action        (s_tdata[ACT_W-1:0]),
        .in_value         (s_tdata[ACT_W+VALUE_W-1:ACT_W]),
        .out_status       (out_status),
        .out_result_value (out_result_value),
        .out_found        (out_found),
        .out_count        (out_count),
        .out_empty_flag   (out_empty_flag),
        .out_full_flag    (out_full_flag)
    );

    // Fields packed from the lowest bit up; the total is exactly six bytes.
    assign m_tdata = {out_full_flag, out_empty_flag, out_count, out_found,
                      out_result_value, out_status};

endmodule
